### hdl/aesd_pkg.sv
package aesd_pkg;

    localparam int KEY_HALVES_DEF = 22;
    localparam int NUM_ROUNDS = 10;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [127:0] block_t;
    typedef logic [7:0] byte_t;

    // control that travels beside each round stage
    typedef struct packed {
        logic valid;
    } stage_ctl_t;

    function automatic byte_t xtime(input byte_t a);
        return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t acc;
        byte_t x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // byte i sits at bits 127-8i
    function automatic byte_t get_byte(input block_t s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t inv_shift_sub(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[get_byte(s, r + 4 * ((c + 4 - r) % 4))];
        return t;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 8 * (4 * c) -: 8] =
                gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
            t[127 - 8 * (4 * c + 1) -: 8] =
                gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
            t[127 - 8 * (4 * c + 2) -: 8] =
                gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
            t[127 - 8 * (4 * c + 3) -: 8] =
                gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
        end
        return t;
    endfunction

endpackage

### hdl/aesd_round.sv
module aesd_round
    import aesd_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  stage_ctl_t ctl_in,
    input  block_t     state_in,
    input  block_t     round_key,
    output stage_ctl_t ctl_out,
    output block_t     state_out
);

    stage_ctl_t ctl_reg;
    block_t state_reg;
    block_t state_next;
    block_t keyed;

    always_comb
    begin
        keyed = state_in ^ round_key;
        if (FIRST)
            state_next = inv_shift_sub(keyed);
        else
            state_next = inv_shift_sub(inv_mix(keyed));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            state_reg <= state_next;
    end

    assign ctl_out = ctl_reg;
    assign state_out = state_reg;

endmodule

### hdl/aes128_block_decrypt_unit.sv
// throughput: one decrypt transaction per cycle unless the output stall holds the pipe;
// a decrypt passes ten round stages plus the output stage
// a load transaction waits until no decrypt is left in the round stages
// the whole pipe holds while the output register is full and not taken
// reset clears all valid bits; round-key store has no reset and must be loaded before use
module aes128_block_decrypt_unit
    import aesd_pkg::*;
#(
    parameter int KEY_HALVES = KEY_HALVES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [4:0]  key_slot,
    input  logic [63:0] key_half_value,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] plain_hi,
    output logic [63:0] plain_lo
);

    logic [63:0] key_reg [KEY_HALVES];
    logic adv;
    logic pipe_busy;
    logic out_valid_reg;
    block_t out_reg;
    stage_ctl_t ctl [NUM_ROUNDS + 1];
    block_t st [NUM_ROUNDS + 1];

    // stall the whole pipe only when the output holds and is not taken
    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        pipe_busy = 1'b0;
        for (int i = 1; i <= NUM_ROUNDS; i++)
            pipe_busy = pipe_busy | ctl[i].valid;
    end

    // a load must not change keys that decrypts in flight still read
    assign in_ready = adv && !(in_valid && req_type == REQ_LOAD && pipe_busy);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && req_type == REQ_LOAD && 32'(key_slot) < KEY_HALVES)
            key_reg[key_slot] <= key_half_value;
    end

    assign ctl[0].valid = in_valid && req_type == REQ_DECRYPT;
    assign st[0] = {block_hi, block_lo};

    genvar g;
    generate
        for (g = 0; g < NUM_ROUNDS; g++)
        begin : g_round
            aesd_round #(.FIRST(g == 0)) u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .ctl_in    (ctl[g]),
                .state_in  (st[g]),
                .round_key ({key_reg[2 * (NUM_ROUNDS - g)], key_reg[2 * (NUM_ROUNDS - g) + 1]}),
                .ctl_out   (ctl[g + 1]),
                .state_out (st[g + 1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= ctl[NUM_ROUNDS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= st[NUM_ROUNDS] ^ {key_reg[0], key_reg[1]};
    end

    assign out_valid = out_valid_reg;
    assign plain_hi = out_reg[127:64];
    assign plain_lo = out_reg[63:0];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(plain_hi) && $stable(plain_lo))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !pipe_busy |-> in_ready)
        else $error("pipe stalled while empty");
    a_first_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !(in_valid && req_type == REQ_DECRYPT) |=> !ctl[1].valid)
        else $error("bubble became valid");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_LOAD |-> !pipe_busy)
        else $error("key load while decrypts in flight");

endmodule
